// File: hw/rtl/lobm_pkg.sv
`default_nettype none
package lobm_pkg;

	localparam int BookDepth = 32;
	localparam int IdxW = $clog2(BookDepth);
	localparam int CntW = $clog2(BookDepth + 1);
	localparam int PriceW = 32;
	localparam int QtyW = 32;
	localparam int TimeW = 48;
	localparam int EntryW = PriceW + QtyW + TimeW;

	localparam logic [1:0] StAccepted = 2'd0;
	localparam logic [1:0] StZeroQty = 2'd1;
	localparam logic [1:0] StDuplicate = 2'd2;
	localparam logic [1:0] StBookFull = 2'd3;

	typedef struct packed {
		logic [PriceW-1:0] price;
		logic [QtyW-1:0] qty;
		logic [TimeW-1:0] time_v;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DUP_RD,
		S_DUP_CMP,
		S_HEAD_RD,
		S_HEAD_CMP,
		S_EMIT,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INS_RD,
		S_INS_CMP,
		S_INS_WR,
		S_STATUS
	} state_t;

	// Strict rank order between two entries on one side.
	function automatic logic ranks_ahead(input logic is_bid, input logic [PriceW-1:0] p1,
		input logic [TimeW-1:0] t1, input logic [PriceW-1:0] p2,
		input logic [TimeW-1:0] t2);
		if (p1 != p2) begin
			return is_bid ? (p1 > p2) : (p1 < p2);
		end
		return t1 < t2;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/lobm_ram.sv
`default_nettype none
module lobm_ram #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: hw/rtl/limit_order_book_matcher_top.sv
// Per item: the item is accepted and the own side is scanned for a duplicate; then each
// crossing head gives one match item, waiting out any output stall, and the head is
// read again; a filled head that leaves has the gap closed by moving entries up; the
// remainder rests, if there is room, by moving entries down, and the status item follows.
// Throughput: one item at a time; in_stall stays high from acceptance until the status
// item is presented. Reset clears the state, both counts and out_valid only.
`default_nettype none
module limit_order_book_matcher_top
	import lobm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic kind,
	input wire logic [PriceW-1:0] order_price,
	input wire logic [QtyW-1:0] order_qty,
	input wire logic [TimeW-1:0] order_time,
	output logic out_valid,
	input wire logic out_stall,
	output logic item_type,
	output logic [PriceW-1:0] bid_price,
	output logic [TimeW-1:0] bid_time,
	output logic [QtyW-1:0] bid_qty,
	output logic [PriceW-1:0] ask_price,
	output logic [TimeW-1:0] ask_time,
	output logic [QtyW-1:0] ask_qty,
	output logic [QtyW-1:0] fill_qty,
	output logic [1:0] status,
	output logic last_item
);
	state_t state_q, state_d;
	logic is_bid_q;
	logic [PriceW-1:0] price_q;
	logic [QtyW-1:0] rem_q;
	logic [TimeW-1:0] time_q;
	logic [CntW-1:0] bid_cnt_q, ask_cnt_q;
	logic [CntW-1:0] idx_q;
	logic [QtyW-1:0] fill_q;
	entry_t head_q;
	logic [1:0] stat_q;

	// Per-side memories; both share one write address and one read address.
	logic bid_we, ask_we;
	logic [IdxW-1:0] waddr, raddr;
	entry_t wdata, bid_rd, ask_rd, own_rd, opp_rd;

	lobm_ram #(.Width(EntryW), .Depth(BookDepth)) u_bid_ram (
		.clk(clk), .we(bid_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(bid_rd)
	);
	lobm_ram #(.Width(EntryW), .Depth(BookDepth)) u_ask_ram (
		.clk(clk), .we(ask_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(ask_rd)
	);

	logic [CntW-1:0] own_cnt, opp_cnt;
	assign own_rd = is_bid_q ? bid_rd : ask_rd;
	assign opp_rd = is_bid_q ? ask_rd : bid_rd;
	assign own_cnt = is_bid_q ? bid_cnt_q : ask_cnt_q;
	assign opp_cnt = is_bid_q ? ask_cnt_q : bid_cnt_q;

	// Shared compare unit.
	logic crosses, dup_hit, ins_here;
	logic [QtyW-1:0] fill_c;
	assign crosses = is_bid_q ? (opp_rd.price <= price_q) : (price_q <= opp_rd.price);
	assign dup_hit = (own_rd.price == price_q) && (own_rd.time_v == time_q);
	assign ins_here = ranks_ahead(is_bid_q, price_q, time_q, own_rd.price, own_rd.time_v);
	assign fill_c = (rem_q < opp_rd.qty) ? rem_q : opp_rd.qty;

	logic out_free;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DUP_RD;
				end
			end
			S_DUP_RD: begin
				if (stat_q == StZeroQty || idx_q == own_cnt) begin
					state_d = (stat_q == StZeroQty) ? S_STATUS : S_HEAD_RD;
				end else begin
					state_d = S_DUP_CMP;
				end
			end
			S_DUP_CMP: state_d = dup_hit ? S_STATUS : S_DUP_RD;
			S_HEAD_RD: begin
				if (rem_q == '0 || opp_cnt == '0) begin
					state_d = S_INS_RD;
				end else begin
					state_d = S_HEAD_CMP;
				end
			end
			S_HEAD_CMP: state_d = crosses ? S_EMIT : S_INS_RD;
			S_EMIT: begin
				if (out_free) begin
					state_d = (head_q.qty == fill_q) ? S_SHIFT_RD : S_HEAD_RD;
				end
			end
			S_SHIFT_RD: state_d = (idx_q + 1'b1 >= opp_cnt) ? S_HEAD_RD : S_SHIFT_WR;
			S_SHIFT_WR: state_d = S_SHIFT_RD;
			S_INS_RD: begin
				if (rem_q == '0 || own_cnt == CntW'(BookDepth) || idx_q == '0) begin
					state_d = (rem_q != '0 && own_cnt != CntW'(BookDepth)) ? S_INS_WR
						: S_STATUS;
				end else begin
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: state_d = ins_here ? S_INS_RD : S_INS_WR;
			S_INS_WR: state_d = S_STATUS;
			S_STATUS: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory access per state; insertion walks from the tail moving entries down.
	always_comb begin
		bid_we = 1'b0;
		ask_we = 1'b0;
		waddr = idx_q[IdxW-1:0];
		raddr = idx_q[IdxW-1:0];
		wdata = head_q;
		unique case (state_q)
			S_HEAD_RD: raddr = '0;
			S_SHIFT_RD: raddr = IdxW'(idx_q + 1'b1);
			S_SHIFT_WR: begin
				waddr = idx_q[IdxW-1:0];
				wdata = opp_rd;
				if (is_bid_q) ask_we = 1'b1;
				else bid_we = 1'b1;
			end
			S_EMIT: begin
				waddr = '0;
				wdata = head_q;
				wdata.qty = head_q.qty - fill_q;
				if (out_free && head_q.qty != fill_q) begin
					if (is_bid_q) ask_we = 1'b1;
					else bid_we = 1'b1;
				end
			end
			S_INS_RD: raddr = IdxW'(idx_q - 1'b1);
			S_INS_CMP: begin
				waddr = idx_q[IdxW-1:0];
				wdata = own_rd;
				if (ins_here) begin
					if (is_bid_q) bid_we = 1'b1;
					else ask_we = 1'b1;
				end
			end
			S_INS_WR: begin
				waddr = idx_q[IdxW-1:0];
				wdata.price = price_q;
				wdata.qty = rem_q;
				wdata.time_v = time_q;
				if (is_bid_q) bid_we = 1'b1;
				else ask_we = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bid_cnt_q <= '0;
			ask_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_EMIT || state_q == S_STATUS) && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (state_q == S_SHIFT_RD && idx_q + 1'b1 >= opp_cnt) begin
				if (is_bid_q) ask_cnt_q <= ask_cnt_q - 1'b1;
				else bid_cnt_q <= bid_cnt_q - 1'b1;
			end
			if (state_q == S_INS_WR) begin
				if (is_bid_q) bid_cnt_q <= bid_cnt_q + 1'b1;
				else ask_cnt_q <= ask_cnt_q + 1'b1;
			end
		end
	end

	// Item context and result registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				is_bid_q <= !kind;
				price_q <= order_price;
				rem_q <= order_qty;
				time_q <= order_time;
				idx_q <= '0;
				stat_q <= (order_qty == '0) ? StZeroQty : StAccepted;
			end
			S_DUP_CMP: begin
				idx_q <= idx_q + 1'b1;
				if (dup_hit) stat_q <= StDuplicate;
			end
			S_HEAD_CMP: begin
				head_q <= opp_rd;
				fill_q <= fill_c;
				// Insertion starts from the tail of the own side.
				if (!crosses) idx_q <= own_cnt;
			end
			S_EMIT: begin
				if (out_free) begin
					item_type <= 1'b0;
					if (is_bid_q) begin
						bid_price <= price_q; bid_time <= time_q; bid_qty <= rem_q;
						ask_price <= head_q.price; ask_time <= head_q.time_v;
						ask_qty <= head_q.qty;
					end else begin
						bid_price <= head_q.price; bid_time <= head_q.time_v;
						bid_qty <= head_q.qty;
						ask_price <= price_q; ask_time <= time_q; ask_qty <= rem_q;
					end
					fill_qty <= fill_q;
					status <= StAccepted;
					last_item <= 1'b0;
					rem_q <= rem_q - fill_q;
					idx_q <= '0;
				end
			end
			S_SHIFT_WR: idx_q <= idx_q + 1'b1;
			// Insertion starts from the tail of the own side.
			S_HEAD_RD: idx_q <= (rem_q == '0 || opp_cnt == '0) ? own_cnt : '0;
			S_INS_CMP: if (ins_here) idx_q <= idx_q - 1'b1;
			S_INS_RD: begin
				if (rem_q != '0 && own_cnt == CntW'(BookDepth)) stat_q <= StBookFull;
			end
			S_STATUS: begin
				if (out_free) begin
					item_type <= 1'b1;
					bid_price <= '0; bid_time <= '0; bid_qty <= '0;
					ask_price <= '0; ask_time <= '0; ask_qty <= '0;
					fill_qty <= '0;
					status <= stat_q;
					last_item <= 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// File: hw/rtl/lobm_checker.sv
`default_nettype none
module lobm_checker
	import lobm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic item_type,
	input wire logic last_item,
	input wire logic [1:0] status,
	input wire logic [QtyW-1:0] fill_qty,
	input wire logic [QtyW-1:0] bid_qty,
	input wire logic [QtyW-1:0] ask_qty
);
	// A status item always closes the input.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (item_type == last_item)) else $error("last flag mismatch");
	// A match fills a nonzero amount, no more than either side holds.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !item_type |-> (fill_qty <= bid_qty && fill_qty <= ask_qty
		&& fill_qty != '0)) else $error("bad fill");
	// Matches carry accepted status.
	a_mstat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !item_type |-> status == StAccepted) else $error("bad status");
	// A stalled item holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fill_qty)) else $error("dropped");
	// Once an item is taken in, the input side is busy on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("not busy after accept");
endmodule

bind limit_order_book_matcher_top lobm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .item_type(item_type),
	.last_item(last_item), .status(status), .fill_qty(fill_qty),
	.bid_qty(bid_qty), .ask_qty(ask_qty)
);
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
	import lobm_pkg::*;

	typedef struct {
		logic is_ask;
		logic [PriceW-1:0] price;
		logic [QtyW-1:0] qty;
		logic [TimeW-1:0] tstamp;
	} order_t;

	typedef struct {
		logic itype;
		logic [PriceW-1:0] bp;
		logic [TimeW-1:0] bt;
		logic [QtyW-1:0] bq;
		logic [PriceW-1:0] ap;
		logic [TimeW-1:0] at;
		logic [QtyW-1:0] aq;
		logic [QtyW-1:0] fq;
		logic [1:0] st;
		logic last;
	} trade_rec_t;

	// One row of the directed table; a fixed status is checked where one is given.
	typedef struct {
		order_t ord;
		logic has_fixed;
		logic [1:0] fixed_st;
	} dir_row_t;

	localparam int QuietLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic [PriceW-1:0] order_price = '0;
	logic [QtyW-1:0] order_qty = '0;
	logic [TimeW-1:0] order_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic item_type;
	logic [PriceW-1:0] bid_price;
	logic [TimeW-1:0] bid_time;
	logic [QtyW-1:0] bid_qty;
	logic [PriceW-1:0] ask_price;
	logic [TimeW-1:0] ask_time;
	logic [QtyW-1:0] ask_qty;
	logic [QtyW-1:0] fill_qty;
	logic [1:0] status;
	logic last_item;

	limit_order_book_matcher_top dut (.*);

	// Shadow book, best entry first on each side.
	logic [PriceW-1:0] shadow_bp[$];
	logic [QtyW-1:0] shadow_bq[$];
	logic [TimeW-1:0] shadow_bt[$];
	logic [PriceW-1:0] shadow_ap[$];
	logic [QtyW-1:0] shadow_aq[$];
	logic [TimeW-1:0] shadow_at[$];

	trade_rec_t pending_trades[$];
	int errors = 0;
	int orders_sent = 0;
	int trades_seen = 0;
	int status_seen = 0;
	int quiet = 0;
	int rest_time_cnt = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic outranks(logic bid, logic [PriceW-1:0] p1, logic [TimeW-1:0] t1,
		logic [PriceW-1:0] p2, logic [TimeW-1:0] t2);
		if (p1 != p2) begin
			return bid ? (p1 > p2) : (p1 < p2);
		end
		return t1 < t2;
	endfunction

	function automatic trade_rec_t status_rec(logic [1:0] st);
		trade_rec_t r;
		r = '{default: '0};
		r.itype = 1'b1;
		r.st = st;
		r.last = 1'b1;
		return r;
	endfunction

	// Works out the trades and final status of one order and updates the shadow book.
	task automatic match_order(order_t o);
		logic bid;
		logic [QtyW-1:0] rem;
		logic [QtyW-1:0] fill;
		logic [QtyW-1:0] oq;
		trade_rec_t r;
		int pos;
		int k;
		bid = !o.is_ask;
		rem = o.qty;
		k = 0;
		if (rem == 0) begin
			pending_trades.push_back(status_rec(StZeroQty));
			return;
		end
		if (bid) begin
			foreach (shadow_bp[i]) begin
				if (shadow_bp[i] == o.price && shadow_bt[i] == o.tstamp) begin
					pending_trades.push_back(status_rec(StDuplicate));
					return;
				end
			end
		end else begin
			foreach (shadow_ap[i]) begin
				if (shadow_ap[i] == o.price && shadow_at[i] == o.tstamp) begin
					pending_trades.push_back(status_rec(StDuplicate));
					return;
				end
			end
		end
		// Walk the opposite head while prices cross.
		while (rem != 0 && k < BookDepth) begin
			r = '{default: '0};
			if (bid) begin
				if (shadow_ap.size() == 0 || shadow_ap[0] > o.price) break;
				oq = shadow_aq[0];
				r.bp = o.price; r.bt = o.tstamp; r.bq = rem;
				r.ap = shadow_ap[0]; r.at = shadow_at[0]; r.aq = oq;
			end else begin
				if (shadow_bp.size() == 0 || o.price > shadow_bp[0]) break;
				oq = shadow_bq[0];
				r.bp = shadow_bp[0]; r.bt = shadow_bt[0]; r.bq = oq;
				r.ap = o.price; r.at = o.tstamp; r.aq = rem;
			end
			fill = (rem < oq) ? rem : oq;
			r.fq = fill;
			pending_trades.push_back(r);
			k++;
			rem -= fill;
			if (bid) begin
				if (oq == fill) begin
					void'(shadow_ap.pop_front()); void'(shadow_aq.pop_front());
					void'(shadow_at.pop_front());
				end else shadow_aq[0] = oq - fill;
			end else begin
				if (oq == fill) begin
					void'(shadow_bp.pop_front()); void'(shadow_bq.pop_front());
					void'(shadow_bt.pop_front());
				end else shadow_bq[0] = oq - fill;
			end
		end
		// Rest the remainder on the own side if there is room.
		if (rem != 0) begin
			if (bid) begin
				if (shadow_bp.size() >= BookDepth) begin
					pending_trades.push_back(status_rec(StBookFull));
					return;
				end
				pos = 0;
				while (pos < shadow_bp.size() &&
					!outranks(1'b1, o.price, o.tstamp, shadow_bp[pos], shadow_bt[pos])) pos++;
				shadow_bp.insert(pos, o.price); shadow_bq.insert(pos, rem);
				shadow_bt.insert(pos, o.tstamp);
			end else begin
				if (shadow_ap.size() >= BookDepth) begin
					pending_trades.push_back(status_rec(StBookFull));
					return;
				end
				pos = 0;
				while (pos < shadow_ap.size() &&
					!outranks(1'b0, o.price, o.tstamp, shadow_ap[pos], shadow_at[pos])) pos++;
				shadow_ap.insert(pos, o.price); shadow_aq.insert(pos, rem);
				shadow_at.insert(pos, o.tstamp);
			end
		end
		pending_trades.push_back(status_rec(StAccepted));
	endtask

	// Receiver: stalls on its own pattern and checks each result item.
	int stall_mode = 0;
	always @(posedge clk) begin
		trade_rec_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				quiet <= 0;
				if (pending_trades.size() == 0) begin
					errors++;
					$display("%0t: unexpected result item type %0b status %0d", $time,
						item_type, status);
				end else begin
					e = pending_trades.pop_front();
					if (item_type) status_seen++; else trades_seen++;
					if ({e.itype, e.bp, e.bt, e.bq, e.ap, e.at, e.aq, e.fq, e.st, e.last} !==
						{item_type, bid_price, bid_time, bid_qty, ask_price, ask_time,
						ask_qty, fill_qty, status, last_item}) begin
						errors++;
						$display("%0t: mismatch expected t%0b b%0d/%0d/%0d a%0d/%0d/%0d f%0d s%0d l%0b",
							$time, e.itype, e.bp, e.bt, e.bq, e.ap, e.at, e.aq, e.fq,
							e.st, e.last);
						$display("%0t:          actual t%0b b%0d/%0d/%0d a%0d/%0d/%0d f%0d s%0d l%0b",
							$time, item_type, bid_price, bid_time, bid_qty, ask_price,
							ask_time, ask_qty, fill_qty, status, last_item);
					end
				end
			end else if (!(in_valid && !in_stall)) begin
				quiet <= quiet + 1;
			end else begin
				quiet <= 0;
			end
			if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Watchdog on cycles with no accepted item on either side.
	always @(posedge clk) begin
		if (quiet >= QuietLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Sends one order, honouring the handshake, then runs the predictor.
	task automatic send_order(order_t o);
		in_valid <= 1'b1;
		kind <= o.is_ask;
		order_price <= o.price;
		order_qty <= o.qty;
		order_time <= o.tstamp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		match_order(o);
		orders_sent++;
	endtask

	task automatic idle_gap(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic order_t mk(logic a, logic [PriceW-1:0] p, logic [QtyW-1:0] q,
		logic [TimeW-1:0] t);
		order_t o;
		o.is_ask = a; o.price = p; o.qty = q; o.tstamp = t;
		return o;
	endfunction

	// Random order: mostly prices near a centre so books cross, some wide noise.
	function automatic order_t rand_order(int centre);
		order_t o;
		o.is_ask = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: o.price = $urandom;
			1: o.price = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: o.price = centre + $urandom_range(0, 12) - 6;
		endcase
		case ($urandom_range(0, 11))
			0: o.qty = '0;
			1: o.qty = $urandom;
			2: o.qty = 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: o.qty = $urandom_range(1, 40);
		endcase
		case ($urandom_range(0, 11))
			0: o.tstamp = TimeW'({$urandom, $urandom});
			1: o.tstamp = (rest_time_cnt > 0) ?
				TimeW'(rest_time_cnt - $urandom_range(0, 2)) : '0;
			default: begin
				rest_time_cnt += $urandom_range(1, 3);
				o.tstamp = TimeW'(rest_time_cnt);
			end
		endcase
		return o;
	endfunction

	dir_row_t dir_tab[$];
	int n;
	int centre;
	trade_rec_t got;

	initial begin
		// Directed table: zero qty, extremes, duplicates, crosses.
		dir_tab.push_back('{mk(1'b0, 32'd100, 32'd0, 48'd1), 1'b1, StZeroQty});
		dir_tab.push_back('{mk(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, {TimeW{1'b1}}), 1'b1,
			StAccepted});
		dir_tab.push_back('{mk(1'b0, 32'hFFFF_FFFF, 32'd5, {TimeW{1'b1}}), 1'b1,
			StDuplicate});
		dir_tab.push_back('{mk(1'b1, 32'd0, 32'd7, 48'd0), 1'b0, 2'd0});
		dir_tab.push_back('{mk(1'b1, 32'd0, 32'hFFFF_FFFF, 48'd2), 1'b0, 2'd0});
		dir_tab.push_back('{mk(1'b1, 32'h5555_AAAA, 32'd3, 48'hAAAA_5555_AAAA), 1'b1,
			StAccepted});
		dir_tab.push_back('{mk(1'b1, 32'h5555_AAAA, 32'd3, 48'hAAAA_5555_AAAA), 1'b1,
			StDuplicate});
		dir_tab.push_back('{mk(1'b0, 32'hAAAA_5555, 32'd1, 48'h5555_AAAA_5555), 1'b0, 2'd0});
		dir_tab.push_back('{mk(1'b0, 32'hAAAA_5555, 32'd10, 48'd9), 1'b0, 2'd0});
		dir_tab.push_back('{mk(1'b1, 32'd10, 32'd4, 48'd12), 1'b0, 2'd0});
		dir_tab.push_back('{mk(1'b1, 32'd10, 32'd4, 48'd11), 1'b0, 2'd0});
		dir_tab.push_back('{mk(1'b0, 32'd0, 32'd1, 48'd3), 1'b0, 2'd0});
		for (int i = 0; i < 11; i++)
			dir_tab.push_back('{mk(1'b1, 32'd20 + i, 32'd2, 48'd100 + i), 1'b0, 2'd0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			send_order(dir_tab[i].ord);
			if (dir_tab[i].has_fixed) begin
				got = pending_trades[pending_trades.size() - 1];
				if (got.st !== dir_tab[i].fixed_st) begin
					errors++;
					$display("%0t: table row %0d expected status %0d, predicted %0d",
						$time, i, dir_tab[i].fixed_st, got.st);
				end
			end
		end
		idle_gap(1);

		// Fill the ask side to its depth, then one more resting ask is dropped.
		while (pending_trades.size() != 0) @(posedge clk);
		while (shadow_ap.size() < BookDepth) begin
			rest_time_cnt++;
			send_order(mk(1'b1, 32'd1000 + rest_time_cnt, 32'd1, 48'd5000 + rest_time_cnt));
		end
		send_order(mk(1'b1, 32'd999_999, 32'd1, 48'd1));
		if (pending_trades[pending_trades.size() - 1].st !== StBookFull) begin
			errors++;
			$display("%0t: expected book full status %0d", $time, StBookFull);
		end
		// A large bid sweeps the whole ask side: the most trades one order can cause.
		send_order(mk(1'b0, 32'hFFFF_FFF0, 32'd1000, 48'd7));

		// Hold off until every expected result has arrived.
		idle_gap(1);
		while (pending_trades.size() != 0) @(posedge clk);
		rest_time_cnt = 10000;

		// Random part in bursts with gaps.
		n = 0;
		centre = 500;
		while (n < 226) begin
			if ($urandom_range(0, 15) == 0) centre = $urandom_range(100, 32'h7FFF_FFFF);
			repeat ($urandom_range(1, 12)) begin
				send_order(rand_order(centre));
				n++;
			end
			if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 20));
		end
		in_valid <= 1'b0;

		while (pending_trades.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("Run covered %0d orders giving %0d trades and %0d status items.",
			orders_sent, trades_seen, status_seen);
		if (errors == 0 && pending_trades.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: limit_order_book_matcher_top.f
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_ram.sv
hw/rtl/limit_order_book_matcher_top.sv
hw/rtl/lobm_checker.sv
tb/testbench.sv
